[rtl/assert_macros.svh]
// assertion macros for the span draw rtl
// no dependencies; included by files that carry concurrent assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted (active low)
`define PFSD_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication, disabled while reset is asserted (active low)
`define PFSD_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

[rtl/pfsd_pkg.sv]
// shared constants, command codes and controller/datapath structs
// no dependencies
`default_nettype none

package pfsd_pkg;

    localparam int PAGES   = 8;
    localparam int COLUMNS = 128;
    localparam int ROWS    = PAGES * 8;
    localparam int DEPTH   = PAGES * COLUMNS;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int IDX_W   = $clog2((COLUMNS > PAGES) ? COLUMNS : PAGES);

    localparam logic [7:0] SOLID_FILL  = 8'hFF;
    localparam logic [7:0] DOTTED_FILL = 8'hAA;

    typedef enum logic [2:0] {
        KIND_POINT = 3'd0,
        KIND_HSPAN = 3'd1,
        KIND_VSOLID = 3'd2,
        KIND_VDOT  = 3'd3,
        KIND_READ  = 3'd4
    } kind_t;

    typedef struct packed {
        logic load;
        logic clr_wr;
        logic rd_issue;
        logic wr_rmw;
        logic wr_point;
        logic step;
        logic res_capture;
    } pfsd_cmd_t;

    typedef struct packed {
        logic is_point;
        logic is_read;
        logic empty;
        logic last;
        logic clr_done;
    } pfsd_status_t;

endpackage

`default_nettype wire

[rtl/pfsd_ram.sv]
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module pfsd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

[rtl/pfsd_datapath.sv]
// datapath: command registers, span bounds, address and mask logic, frame ram
// depends on pfsd_pkg and pfsd_ram
`default_nettype none

module pfsd_datapath import pfsd_pkg::*; (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic [2:0]   in_kind,
    input  wire logic [5:0]   in_row,
    input  wire logic [6:0]   in_column,
    input  wire logic [7:0]   in_start,
    input  wire logic [7:0]   in_end,
    input  wire logic [2:0]   in_page,
    input  wire pfsd_cmd_t    cmd,
    output pfsd_status_t      status,
    output logic [7:0]        result
);

    logic [2:0]        kind_reg;
    logic [5:0]        row_reg;
    logic [6:0]        column_reg;
    logic [2:0]        page_reg;
    logic [4:0]        sp_reg;
    logic [2:0]        sb_reg;
    logic [5:0]        ep_reg;
    logic [2:0]        eb_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [IDX_W-1:0]  last_reg;
    logic              empty_reg;
    logic [7:0]        res_reg;
    logic [ADDR_W-1:0] clr_reg;

    logic [8:0]        start9, end9, hs_end, hs_last, vs_end, vep9, lastp;
    logic              col_ok, row_ok, page_ok;
    logic [IDX_W-1:0]  first_c, last_c;
    logic              empty_c;

    logic [IDX_W-1:0]  pg_sel, col_sel;
    logic [ADDR_W-1:0] addr;
    logic              at_sp, at_ep;
    logic [7:0]        vmask, hmask, rmw_mask, pt_data;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]        wr_data;
    logic [7:0]        rd_data;

    // span bounds and clipping, evaluated on the incoming item
    always_comb begin
        start9  = {1'b0, in_start};
        end9    = {1'b0, in_end};
        hs_end  = (end9 > 9'(COLUMNS)) ? 9'(COLUMNS) : end9;
        hs_last = hs_end - 9'd1;
        vs_end  = (end9 > 9'(ROWS)) ? 9'(ROWS) : end9;
        vep9    = {3'b000, vs_end[8:3]};
        lastp   = (vep9 > 9'(PAGES - 1)) ? 9'(PAGES - 1) : vep9;
        col_ok  = 9'(in_column) < 9'(COLUMNS);
        row_ok  = 9'(in_row) < 9'(ROWS);
        page_ok = 9'(in_page) < 9'(PAGES);
        case (in_kind)
            KIND_POINT: begin
                first_c = '0;
                last_c  = IDX_W'(PAGES - 1);
                empty_c = !col_ok;
            end
            KIND_HSPAN: begin
                first_c = in_start[IDX_W-1:0];
                last_c  = hs_last[IDX_W-1:0];
                empty_c = !row_ok || (start9 >= hs_end);
            end
            KIND_VSOLID, KIND_VDOT: begin
                first_c = IDX_W'(in_start[7:3]);
                last_c  = lastp[IDX_W-1:0];
                empty_c = !col_ok || (start9 >= vs_end);
            end
            KIND_READ: begin
                first_c = '0;
                last_c  = '0;
                empty_c = !(col_ok && page_ok);
            end
            default: begin
                first_c = '0;
                last_c  = '0;
                empty_c = 1'b1;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            kind_reg   <= in_kind;
            row_reg    <= in_row;
            column_reg <= in_column;
            page_reg   <= in_page;
            sp_reg     <= in_start[7:3];
            sb_reg     <= in_start[2:0];
            ep_reg     <= vs_end[8:3];
            eb_reg     <= vs_end[2:0];
            idx_reg    <= first_c;
            last_reg   <= last_c;
            empty_reg  <= empty_c;
        end else if (cmd.step) begin
            idx_reg <= idx_reg + IDX_W'(1);
        end
        if (cmd.res_capture) begin
            res_reg <= (kind_reg == KIND_READ && !empty_reg) ? rd_data : 8'h00;
        end
    end

    // clearing pass address counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg <= '0;
        end else if (cmd.clr_wr) begin
            clr_reg <= clr_reg + ADDR_W'(1);
        end
    end

    // byte address of the current step
    always_comb begin
        case (kind_reg)
            KIND_HSPAN: begin
                pg_sel  = IDX_W'(row_reg[5:3]);
                col_sel = idx_reg;
            end
            KIND_READ: begin
                pg_sel  = IDX_W'(page_reg);
                col_sel = IDX_W'(column_reg);
            end
            default: begin
                pg_sel  = idx_reg;
                col_sel = IDX_W'(column_reg);
            end
        endcase
        addr = ADDR_W'(pg_sel) * ADDR_W'(COLUMNS) + ADDR_W'(col_sel);
    end

    // edge pages get the covered bits only, middle pages the fill pattern
    always_comb begin
        at_sp = 9'(idx_reg) == {4'b0000, sp_reg};
        at_ep = 9'(idx_reg) == {3'b000, ep_reg};
        if (at_sp || at_ep) begin
            vmask = 8'hFF;
            if (at_sp) begin
                vmask = vmask & (8'hFF << sb_reg);
            end
            if (at_ep) begin
                vmask = vmask & ((8'd1 << eb_reg) - 8'd1);
            end
        end else begin
            vmask = (kind_reg == KIND_VDOT) ? DOTTED_FILL : SOLID_FILL;
        end
        hmask    = 8'd1 << row_reg[2:0];
        rmw_mask = (kind_reg == KIND_HSPAN) ? hmask : vmask;
        // only the page that holds the row gets the row bit; every other page is written zero
        pt_data  = (9'(idx_reg) == 9'(row_reg[5:3])) ? hmask : 8'h00;
    end

    always_comb begin
        wr_en = cmd.clr_wr | cmd.wr_rmw | cmd.wr_point;
        if (cmd.clr_wr) begin
            wr_addr = clr_reg;
            wr_data = 8'h00;
        end else begin
            wr_addr = addr;
            wr_data = cmd.wr_rmw ? (rd_data | rmw_mask) : pt_data;
        end
    end

    pfsd_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_frame_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (cmd.rd_issue),
        .rd_addr (addr),
        .rd_data (rd_data)
    );

    always_comb begin
        status.is_point = kind_reg == KIND_POINT;
        status.is_read  = kind_reg == KIND_READ;
        status.empty    = empty_reg;
        status.last     = idx_reg == last_reg;
        status.clr_done = clr_reg == ADDR_W'(DEPTH - 1);
    end

    assign result = res_reg;

endmodule

`default_nettype wire

[rtl/pfsd_controller.sv]
// controller: clearing pass, per-item sequencing and output handshake
// depends on pfsd_pkg and assert_macros.svh
`default_nettype none

`include "assert_macros.svh"

module pfsd_controller import pfsd_pkg::*; (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    input  wire pfsd_status_t status,
    output pfsd_cmd_t         cmd
);

    typedef enum logic [7:0] {
        S_CLEAR = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_EVAL  = 8'b0000_0100,
        S_RD    = 8'b0000_1000,
        S_WR    = 8'b0001_0000,
        S_PT    = 8'b0010_0000,
        S_RDB   = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   can_load;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        can_load   = !out_valid_reg || m_tready;
        case (state_reg)
            S_CLEAR: begin
                cmd.clr_wr = 1'b1;
                if (status.clr_done) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = S_EVAL;
                end
            end
            S_EVAL: begin
                if (status.empty) begin
                    state_next = S_DONE;
                end else if (status.is_read) begin
                    state_next = S_RDB;
                end else if (status.is_point) begin
                    state_next = S_PT;
                end else begin
                    state_next = S_RD;
                end
            end
            S_RD: begin
                cmd.rd_issue = 1'b1;
                state_next   = S_WR;
            end
            S_WR: begin
                cmd.wr_rmw = 1'b1;
                if (status.last) begin
                    state_next = S_DONE;
                end else begin
                    cmd.step   = 1'b1;
                    state_next = S_RD;
                end
            end
            S_PT: begin
                cmd.wr_point = 1'b1;
                if (status.last) begin
                    state_next = S_DONE;
                end else begin
                    cmd.step = 1'b1;
                end
            end
            S_RDB: begin
                cmd.rd_issue = 1'b1;
                state_next   = S_DONE;
            end
            S_DONE: begin
                if (can_load) begin
                    cmd.res_capture = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default: begin
                state_next = S_CLEAR;
            end
        endcase
        out_valid_next = (out_valid_reg && !m_tready) || cmd.res_capture;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign s_tready = state_reg == S_IDLE;
    assign m_tvalid = out_valid_reg;

    `PFSD_ASSERT_NEXT(a_result_held, aclk, aresetn, out_valid_reg && !m_tready, out_valid_reg)
    `PFSD_ASSERT_NEXT(a_accept_eval, aclk, aresetn, s_tvalid && s_tready, state_reg == S_EVAL)
    `PFSD_ASSERT_NEXT(a_done_result, aclk, aresetn, state_reg == S_DONE && can_load, out_valid_reg && state_reg == S_IDLE)

endmodule

`default_nettype wire

[rtl/page_framebuffer_span_draw_unit.sv]
// 64x128 page framebuffer span draw unit: one command item in, one byte out
// empty or unused kinds go straight to the result, a read does one ram read, a
// point writes all PAGES pages, a span read-modify-writes each byte it touches
// through the single frame ram; next item is taken once the result is registered
// reset: a clearing pass writes zero to all PAGES*COLUMNS (1024) bytes, one per
// cycle, with s_tready low; depends on pfsd_pkg, pfsd_controller, pfsd_datapath
`default_nettype none

module page_framebuffer_span_draw_unit import pfsd_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // row[5:0], column[12:6], span_start[20:13], span_end[28:21], page[31:29]
    input  wire logic [31:0] s_tdata,
    // kind[2:0]
    input  wire logic [2:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // read_data[7:0]
    output logic [7:0]       m_tdata
);

    pfsd_cmd_t    cmd;
    pfsd_status_t status;

    pfsd_controller u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    pfsd_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_kind   (s_tuser),
        .in_row    (s_tdata[5:0]),
        .in_column (s_tdata[12:6]),
        .in_start  (s_tdata[20:13]),
        .in_end    (s_tdata[28:21]),
        .in_page   (s_tdata[31:29]),
        .cmd       (cmd),
        .status    (status),
        .result    (m_tdata)
    );

endmodule

`default_nettype wire
